>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for the concurrent checks used by the fan curve checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising edge
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> sv/fcs_pkg.sv
// ----------------------------------------------------------------------------
// fcs_pkg
// Widths, constants and interface types shared by the fan curve modules.
// ----------------------------------------------------------------------------
package fcs_pkg;

   localparam int FRACTION_BITS = 8;

   localparam int TEMP_W   = 8;
   localparam int POWER_W  = 7;
   localparam int SMOOTH_W = POWER_W + FRACTION_BITS;
   localparam int NUMER_W  = TEMP_W + POWER_W + FRACTION_BITS;
   localparam int DIV_W    = SMOOTH_W + 2;
   localparam int REM_W    = TEMP_W + 1;
   localparam int STEP_W   = $clog2(DIV_W + 1);

   localparam logic [POWER_W-1:0]  FULL_POWER = {POWER_W{1'b1}};
   localparam logic [SMOOTH_W-1:0] FULL_LEVEL = SMOOTH_W'(FULL_POWER) << FRACTION_BITS;

   localparam logic [TEMP_W-1:0] LOW_RESET      = 8'd67;
   localparam logic [TEMP_W-1:0] HIGH_RESET     = 8'd78;
   localparam logic [TEMP_W-1:0] SMOOTH_DIVISOR = 8'd3;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH = 2'd1;

   typedef struct packed {
      logic                start;
      logic [REM_W-1:0]    rem_init;
      logic [DIV_W-1:0]    numer;
      logic [TEMP_W-1:0]   divisor;
      logic [STEP_W-1:0]   steps;
   } fcs_div_req_type;

   typedef struct packed {
      logic                done;
      logic [DIV_W-1:0]    quot;
   } fcs_div_rsp_type;

endpackage

>>> sv/fcs_div.sv
// ----------------------------------------------------------------------------
// fcs_div
// Bit-serial restoring divider: one quotient bit per cycle, numerator
// shifted in MSB first behind a preloaded partial remainder.
// ----------------------------------------------------------------------------
module fcs_div (
   input  logic                    clock,
   input  logic                    reset,
   input  fcs_pkg::fcs_div_req_type div_req,
   output fcs_pkg::fcs_div_rsp_type div_rsp
);
   import fcs_pkg::*;

   logic [REM_W-1:0]  rem_ff,  rem_in;
   logic [DIV_W-1:0]  num_ff,  num_in;
   logic [DIV_W-1:0]  quot_ff, quot_in;
   logic [TEMP_W-1:0] dvs_ff,  dvs_in;
   logic [STEP_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [REM_W-1:0]  trial;
   logic              fits;

   // rem_ff is always below the divisor, so the trial fits in REM_W bits
   assign trial = {rem_ff[REM_W-2:0], num_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.rem_init;
         num_in  = div_req.numer;
         quot_in = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? trial - {1'b0, dvs_ff} : trial;
         num_in  = {num_ff[DIV_W-2:0], 1'b0};
         quot_in = {quot_ff[DIV_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule

>>> sv/fan_curve_with_smoothing_top.sv
// ----------------------------------------------------------------------------
// fan_curve_with_smoothing_top
// Maps a temperature word to a linear fan power and smooths it as
// s = (2s + p) / 3 in fixed point; reports integer power and fan toggles.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  req       in         req_valid/req_stall   req_temperature
//  rsp       out        rsp_valid/rsp_stall   rsp_fan_power, rsp_sensor_error,
//                                             rsp_fan_toggled
//  csr       in         csr_write             csr_index, csr_wdata
//
//  One word at a time. A sample between the thresholds runs a 15-step curve
//  division and a 17-step divide by three, both on the one serial divider; a
//  sample at or outside a threshold runs only the divide by three, and a zero
//  sample runs neither. Sync active-high reset; thresholds return to 67 and 78.
//  A result held by rsp_stall waits in the output register; the next word is
//  taken meanwhile and its result waits in turn until that register frees.
// ----------------------------------------------------------------------------
module fan_curve_with_smoothing_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fcs_pkg::TEMP_W-1:0]         req_temperature,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fcs_pkg::POWER_W-1:0]        rsp_fan_power,
   output logic                               rsp_sensor_error,
   output logic                               rsp_fan_toggled,
   input  logic                               csr_write,
   input  logic [fcs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [fcs_pkg::TEMP_W-1:0]         csr_wdata
);
   import fcs_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CURVE    = 3'd1;
   localparam logic [2:0] ST_SM_START = 3'd2;
   localparam logic [2:0] ST_SMOOTH   = 3'd3;
   localparam logic [2:0] ST_PUT      = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [TEMP_W-1:0]   low_ff, low_in;
   logic [TEMP_W-1:0]   high_ff, high_in;
   logic [SMOOTH_W-1:0] s_ff, s_in;
   logic                fan_on_ff, fan_on_in;
   logic [SMOOTH_W-1:0] p_ff, p_in;
   logic [POWER_W-1:0]  res_power_ff, res_power_in;
   logic                res_err_ff, res_err_in;
   logic                res_tog_ff, res_tog_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [POWER_W-1:0]  rsp_power_ff, rsp_power_in;
   logic                rsp_err_ff, rsp_err_in;
   logic                rsp_tog_ff, rsp_tog_in;

   fcs_div_req_type     div_req;
   fcs_div_rsp_type     div_rsp;

   logic                    req_take;
   logic                    out_free;
   logic [TEMP_W-1:0]       diff;
   logic [TEMP_W+POWER_W-1:0] curve_prod;
   logic [NUMER_W-1:0]      curve_num;
   logic [POWER_W-1:0]      new_level;
   logic                    new_on;

   assign req_stall = state_ff != ST_IDLE;
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign diff       = req_temperature - low_ff;
   assign curve_prod = (TEMP_W+POWER_W)'(diff) * (TEMP_W+POWER_W)'(FULL_POWER);
   assign curve_num  = NUMER_W'(curve_prod) << FRACTION_BITS;

   assign new_level = div_rsp.quot[SMOOTH_W-1:FRACTION_BITS];
   assign new_on    = new_level != '0;

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_LOW:  low_in  = csr_wdata;
            CSR_HIGH: high_in = csr_wdata;
            default:  ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      s_in         = s_ff;
      fan_on_in    = fan_on_ff;
      p_in         = p_ff;
      res_power_in = res_power_ff;
      res_err_in   = res_err_ff;
      res_tog_in   = res_tog_ff;
      div_req      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_temperature == '0) begin
                  res_power_in = s_ff[SMOOTH_W-1:FRACTION_BITS];
                  res_err_in   = 1'b1;
                  res_tog_in   = 1'b0;
                  state_in     = ST_PUT;
               end else if (req_temperature <= low_ff) begin
                  p_in     = '0;
                  state_in = ST_SM_START;
               end else if (req_temperature >= high_ff) begin
                  p_in     = FULL_LEVEL;
                  state_in = ST_SM_START;
               end else begin
                  // top bits of the numerator are already below the span
                  div_req.start    = 1'b1;
                  div_req.rem_init = REM_W'(curve_num[NUMER_W-1:SMOOTH_W]);
                  div_req.numer    = {curve_num[SMOOTH_W-1:0], 2'b00};
                  div_req.divisor  = high_ff - low_ff;
                  div_req.steps    = STEP_W'(SMOOTH_W);
                  state_in         = ST_CURVE;
               end
            end
         end
         ST_CURVE: begin
            if (div_rsp.done) begin
               p_in     = div_rsp.quot[SMOOTH_W-1:0];
               state_in = ST_SM_START;
            end
         end
         ST_SM_START: begin
            div_req.start    = 1'b1;
            div_req.rem_init = '0;
            div_req.numer    = DIV_W'({s_ff, 1'b0}) + DIV_W'(p_ff);
            div_req.divisor  = SMOOTH_DIVISOR;
            div_req.steps    = STEP_W'(DIV_W);
            state_in         = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            if (div_rsp.done) begin
               s_in         = div_rsp.quot[SMOOTH_W-1:0];
               res_power_in = new_level;
               res_err_in   = 1'b0;
               res_tog_in   = new_on != fan_on_ff;
               fan_on_in    = new_on;
               state_in     = ST_PUT;
            end
         end
         ST_PUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_power_in = rsp_power_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_tog_in   = rsp_tog_ff;
      if (state_ff == ST_PUT && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_power_in = res_power_ff;
         rsp_err_in   = res_err_ff;
         rsp_tog_in   = res_tog_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         low_ff       <= LOW_RESET;
         high_ff      <= HIGH_RESET;
         s_ff         <= '0;
         fan_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         s_ff         <= s_in;
         fan_on_ff    <= fan_on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      res_power_ff <= res_power_in;
      res_err_ff   <= res_err_in;
      res_tog_ff   <= res_tog_in;
      rsp_power_ff <= rsp_power_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_tog_ff   <= rsp_tog_in;
   end

   fcs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fan_power    = rsp_power_ff;
   assign rsp_sensor_error = rsp_err_ff;
   assign rsp_fan_toggled  = rsp_tog_ff;

endmodule

>>> sv/fcs_check.sv
// ----------------------------------------------------------------------------
// fcs_check
// Port-level checks on the fan curve block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcs_check (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [fcs_pkg::POWER_W-1:0]  rsp_fan_power,
   input logic                         rsp_sensor_error,
   input logic                         rsp_fan_toggled
);

   logic [fcs_pkg::POWER_W+1:0] rsp_word;

   assign rsp_word = {rsp_fan_power, rsp_sensor_error, rsp_fan_toggled};

   // a held result word keeps its contents
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

   // a skipped sample never reports a fan change
   `ASSERT_IMPLY(a_err_no_toggle, clock, reset, rsp_valid && rsp_sensor_error, !rsp_fan_toggled)

   // one word in flight: the input closes right after a take
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)

   // reset leaves no result pending
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind fan_curve_with_smoothing_top fcs_check u_fcs_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_fan_power    (rsp_fan_power),
   .rsp_sensor_error (rsp_sensor_error),
   .rsp_fan_toggled  (rsp_fan_toggled)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fan curve block: a queue-fed driver sends
// temperature words with random gaps, the result side stalls at random, and
// every accepted result is compared against an in-bench curve and smoothing
// predictor. Thresholds change between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
   import fcs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic [POWER_W-1:0] fan_power;
      logic               sensor_error;
      logic               fan_toggled;
   } fan_result_type;

   typedef enum {RUN_COLD, RUN_HOT, RUN_MID, RUN_ANY, RUN_FAULT} run_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [TEMP_W-1:0]      req_temperature = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [POWER_W-1:0]     rsp_fan_power;
   logic                   rsp_sensor_error;
   logic                   rsp_fan_toggled;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LOW;
   logic [TEMP_W-1:0]      csr_wdata = '0;

   // predictor state and its copy of the thresholds
   logic [TEMP_W-1:0]   thr_low  = LOW_RESET;
   logic [TEMP_W-1:0]   thr_high = HIGH_RESET;
   logic [SMOOTH_W-1:0] smooth_level = '0;
   logic                fan_on = 1'b0;

   logic [TEMP_W-1:0] pending_temps[$];
   fan_result_type    power_due[$];
   int                n_queued = 0;
   int                n_accepted = 0;
   int                mismatches = 0;
   int                quiet_cycles = 0;
   int unsigned       gap_left = 0;
   int unsigned       stall_left = 0;
   logic              req_fire = 1'b0;
   logic              rsp_fire = 1'b0;
   bit                calm = 1'b0;

   fan_curve_with_smoothing_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_temperature  (req_temperature),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_fan_power    (rsp_fan_power),
      .rsp_sensor_error (rsp_sensor_error),
      .rsp_fan_toggled  (rsp_fan_toggled),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned draw_wait();
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 13);
   endfunction

   // linear curve point, then s = (2s + p) / 3, all in fixed point
   function automatic fan_result_type predict_fan(logic [TEMP_W-1:0] temp);
      fan_result_type r;
      int unsigned t, lo, hi, target, next_level;
      logic        on_now;
      t  = temp;
      lo = thr_low;
      hi = thr_high;
      if (t == 0) begin
         r.fan_power    = POWER_W'(smooth_level >> FRACTION_BITS);
         r.sensor_error = 1'b1;
         r.fan_toggled  = 1'b0;
         return r;
      end
      if (t <= lo) target = 0;
      else if (t >= hi) target = int'(FULL_POWER) << FRACTION_BITS;
      else target = (((t - lo) * int'(FULL_POWER)) << FRACTION_BITS) / (hi - lo);
      next_level   = (2 * int'(smooth_level) + target) / 3;
      smooth_level = SMOOTH_W'(next_level);
      r.fan_power    = POWER_W'(smooth_level >> FRACTION_BITS);
      on_now         = r.fan_power != '0;
      r.sensor_error = 1'b0;
      r.fan_toggled  = on_now != fan_on;
      fan_on         = on_now;
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // word driver: one item at a time, random gap after each accepted word
   always @(negedge clock) begin : drive_req
      logic hold;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         hold = req_valid && !req_fire;
         if (req_valid && req_fire) gap_left = draw_wait();
         if (!hold && gap_left > 0) begin
            gap_left--;
         end else if (!hold && pending_temps.size() > 0) begin
            req_temperature <= pending_temps.pop_front();
            hold = 1'b1;
         end
         req_valid <= hold;
      end
   end

   // result side back-pressure
   always @(negedge clock) begin : drive_rsp
      if (rsp_fire) stall_left = draw_wait();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor, predictor hook and watchdog
   always @(posedge clock) begin : watch
      fan_result_type want;
      req_fire <= !reset && req_valid && !req_stall;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         quiet_cycles++;
         if (csr_write) quiet_cycles = 0;
         if (rsp_valid && !rsp_stall) begin
            quiet_cycles = 0;
            if (power_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: power %0d err %0b tog %0b",
                               rsp_fan_power, rsp_sensor_error, rsp_fan_toggled));
            end else begin
               want = power_due.pop_front();
               if (rsp_fan_power !== want.fan_power)
                  report_mismatch($sformatf("fan_power got %0d want %0d",
                                  rsp_fan_power, want.fan_power));
               if (rsp_sensor_error !== want.sensor_error)
                  report_mismatch($sformatf("sensor_error got %0b want %0b",
                                  rsp_sensor_error, want.sensor_error));
               if (rsp_fan_toggled !== want.fan_toggled)
                  report_mismatch($sformatf("fan_toggled got %0b want %0b",
                                  rsp_fan_toggled, want.fan_toggled));
            end
         end
         // predict after the check so a same-edge word never masks a stray result
         if (req_valid && !req_stall) begin
            power_due.push_back(predict_fan(req_temperature));
            n_accepted++;
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic push_temp(int unsigned t);
      pending_temps.push_back(TEMP_W'(t));
      n_queued++;
   endtask

   task automatic write_threshold(logic [CSR_INDEX_W-1:0] idx, int unsigned value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= TEMP_W'(value);
      if (idx == CSR_LOW) thr_low = TEMP_W'(value);
      else thr_high = TEMP_W'(value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // wait for every word to be taken and answered, then let the pipe drain
   task automatic settle();
      while (n_accepted != n_queued || power_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic int unsigned pick_temp(run_kind_type kind);
      int unsigned lo, hi;
      lo = thr_low;
      hi = thr_high;
      case (kind)
         RUN_FAULT: return 0;
         RUN_COLD: begin
            if (lo == 0) return $urandom_range(1, 255);
            return $urandom_range(1, lo);
         end
         RUN_HOT: begin
            return $urandom_range((hi == 0) ? 1 : hi, 255);
         end
         RUN_MID: begin
            if (hi > lo + 1) return $urandom_range(lo + 1, hi - 1);
            return $urandom_range(1, 255);
         end
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   function automatic run_kind_type pick_run();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return RUN_FAULT;
      if (r <= 2) return RUN_COLD;
      if (r <= 4) return RUN_HOT;
      if (r <= 7) return RUN_MID;
      return RUN_ANY;
   endfunction

   initial begin : stimulus
      int unsigned low_set[7]  = '{0, 255, 100, 0, 254, 255, 0};
      int unsigned high_set[7] = '{255, 0, 100, 1, 255, 255, 0};
      int unsigned lo, hi, run_len, phase_items;
      run_kind_type kind;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset thresholds 67..78
      push_temp(0);
      repeat (3) push_temp(255);
      push_temp(0);
      push_temp(67); push_temp(68); push_temp(72); push_temp(77); push_temp(78);
      push_temp(79); push_temp(128); push_temp(85); push_temp(170);
      repeat (8) push_temp(1);
      push_temp(0);
      settle();

      for (int phase = 1; phase <= 22; phase++) begin
         if (phase <= 7) begin
            lo = low_set[phase-1];
            hi = high_set[phase-1];
         end else begin
            lo = $urandom_range(0, 250);
            hi = lo + $urandom_range(1, 40);
            if (hi > 255) hi = 255;
         end
         calm = (phase % 5 == 3);
         write_threshold(CSR_LOW, lo);
         write_threshold(CSR_HIGH, hi);
         phase_items = 0;
         while (phase_items < 46) begin
            kind    = pick_run();
            run_len = (kind == RUN_FAULT) ? $urandom_range(1, 3) : $urandom_range(1, 16);
            repeat (run_len) push_temp(pick_temp(kind));
            phase_items += run_len;
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
